>>> rtl/core/text_console_writer_unit_defines.svh
// Assertion shorthands for the console writer.
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TCW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps
package tcw_pkg;

	localparam int TCW_COLUMNS = 80;
	localparam int TCW_ROWS    = 25;

	localparam logic [15:0] TCW_BLANK_CELL = 16'h0F20;
	localparam logic [7:0]  TCW_NEWLINE    = 8'd10;
	localparam logic [7:0]  TCW_ATTR_RESET = 8'h0F;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2
	} tcw_op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_COPY,
		ST_FILL,
		ST_DONE
	} tcw_state_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} tcw_req_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [4:0]  cursor_row_now;
		logic [6:0]  cursor_col_now;
		logic        scrolled;
	} tcw_rsp_t;

	typedef struct packed {
		logic load_item;
		logic write_char;
		logic adv_col;
		logic new_row;
		logic col_home;
		logic cur_home;
		logic start_copy;
		logic start_fill_all;
		logic start_fill_last;
		logic copy_step;
		logic fill_step;
		logic take_cell;
		logic load_out;
	} tcw_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       is_newline;
		logic       col_last;
		logic       row_last;
		logic       sweep_last;
		logic       out_free;
		logic       wr_busy;
	} tcw_status_t;

endpackage

>>> rtl/core/tcw_ram.sv
`timescale 1ns / 1ps
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> rtl/core/tcw_ctrl.sv
`timescale 1ns / 1ps
module tcw_ctrl
	import tcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  tcw_status_t st,
	output tcw_cmd_t    cmd
);

	tcw_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				// power-up blanking sweep
				cmd.fill_step = 1'b1;
				if (st.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (st.op)
					OP_WRITE: begin
						if (!st.is_newline) begin
							cmd.write_char = 1'b1;
						end
						if (st.is_newline || st.col_last) begin
							if (st.row_last) begin
								cmd.col_home   = 1'b1;
								cmd.start_copy = 1'b1;
								state_d        = ST_COPY;
							end else begin
								cmd.new_row = 1'b1;
								state_d     = ST_DONE;
							end
						end else begin
							cmd.adv_col = 1'b1;
							state_d     = ST_DONE;
						end
					end
					OP_CLEAR: begin
						cmd.cur_home       = 1'b1;
						cmd.start_fill_all = 1'b1;
						state_d            = ST_FILL;
					end
					OP_READ: begin
						state_d = ST_READ;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_READ: begin
				cmd.take_cell = 1'b1;
				state_d       = ST_DONE;
			end
			ST_COPY: begin
				cmd.copy_step = 1'b1;
				if (st.sweep_last) begin
					cmd.start_fill_last = 1'b1;
					state_d             = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (st.sweep_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

endmodule

>>> rtl/core/tcw_dp.sv
`timescale 1ns / 1ps
module tcw_dp
	import tcw_pkg::*;
#(
	parameter int COLUMNS = TCW_COLUMNS,
	parameter int ROWS    = TCW_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  tcw_req_t    req_data,
	input  logic        cfg_valid,
	input  logic [7:0]  cfg_data,
	input  tcw_cmd_t    cmd,
	output tcw_status_t st,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output tcw_rsp_t    rsp_data
);

	localparam int TOTAL  = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(TOTAL);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);

	localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(TOTAL - 1);
	localparam logic [ADDR_W-1:0] COPY_LAST    = ADDR_W'((ROWS - 1) * COLUMNS - 1);
	localparam logic [ADDR_W-1:0] BOTTOM_FIRST = ADDR_W'((ROWS - 1) * COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STRIDE   = ADDR_W'(COLUMNS);

	logic [7:0]        attr_q;
	tcw_req_t          item_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ADDR_W-1:0] ptr_q, end_q;
	logic [15:0]       cell_q;
	logic              scrolled_q;
	logic              wr_valid_s1, wr_blank_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              rsp_valid_q;
	tcw_rsp_t          rsp_q;

	logic              rd_in_range;
	logic [ADDR_W-1:0] rd_item_addr, cur_addr, ram_rd_addr, ram_wr_addr;
	logic [15:0]       ram_rd_data, ram_wr_data;
	logic              ram_wr_en;
	logic [ROW_W+4:0]  row_ext;
	logic [COL_W+6:0]  col_ext;

	assign rd_in_range = ({27'd0, item_q.read_row} < 32'(ROWS))
		&& ({25'd0, item_q.read_col} < 32'(COLUMNS));
	assign rd_item_addr = rd_in_range
		? ADDR_W'(item_q.read_row) * ROW_STRIDE + ADDR_W'(item_q.read_col) : '0;
	assign cur_addr = ADDR_W'(row_q) * ROW_STRIDE + ADDR_W'(col_q);

	// copy reads one row ahead; the write lands in the following cycle via the s1 stage
	assign ram_rd_addr = cmd.copy_step ? ptr_q + ROW_STRIDE : rd_item_addr;

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = cur_addr;
		ram_wr_data = {attr_q, item_q.char_code};
		if (wr_valid_s1) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = wr_addr_s1;
			ram_wr_data = wr_blank_s1 ? TCW_BLANK_CELL : ram_rd_data;
		end else if (cmd.write_char) begin
			ram_wr_en = 1'b1;
		end
	end

	tcw_ram #(
		.WIDTH (16),
		.DEPTH (TOTAL)
	) u_screen (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q      <= TCW_ATTR_RESET;
			row_q       <= '0;
			col_q       <= '0;
			ptr_q       <= '0;
			end_q       <= LAST_ADDR;
			wr_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				attr_q <= cfg_data;
			end

			priority if (cmd.cur_home) begin
				row_q <= '0;
				col_q <= '0;
			end else if (cmd.new_row) begin
				row_q <= row_q + ROW_W'(1);
				col_q <= '0;
			end else if (cmd.col_home) begin
				col_q <= '0;
			end else if (cmd.adv_col) begin
				col_q <= col_q + COL_W'(1);
			end

			priority if (cmd.start_copy) begin
				ptr_q <= '0;
				end_q <= COPY_LAST;
			end else if (cmd.start_fill_all) begin
				ptr_q <= '0;
				end_q <= LAST_ADDR;
			end else if (cmd.start_fill_last) begin
				ptr_q <= BOTTOM_FIRST;
				end_q <= LAST_ADDR;
			end else if (cmd.copy_step || cmd.fill_step) begin
				ptr_q <= ptr_q + ADDR_W'(1);
			end

			wr_valid_s1 <= cmd.copy_step || cmd.fill_step;

			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign row_ext = {5'd0, row_q};
	assign col_ext = {7'd0, col_q};

	always_ff @(posedge clk) begin
		wr_addr_s1  <= ptr_q;
		wr_blank_s1 <= cmd.fill_step;
		if (cmd.load_item) begin
			item_q     <= req_data;
			cell_q     <= '0;
			scrolled_q <= 1'b0;
		end else begin
			if (cmd.take_cell) begin
				cell_q <= rd_in_range ? ram_rd_data : '0;
			end
			if (cmd.start_copy) begin
				scrolled_q <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			rsp_q.cell_value     <= cell_q;
			rsp_q.cursor_row_now <= row_ext[4:0];
			rsp_q.cursor_col_now <= col_ext[6:0];
			rsp_q.scrolled       <= scrolled_q;
		end
	end

	assign st.op         = item_q.op;
	assign st.is_newline = (item_q.char_code == TCW_NEWLINE);
	assign st.col_last   = (col_q == COL_W'(COLUMNS - 1));
	assign st.row_last   = (row_q == ROW_W'(ROWS - 1));
	assign st.sweep_last = (ptr_q == end_q);
	assign st.out_free   = !rsp_valid_q || rsp_ready;
	assign st.wr_busy    = wr_valid_s1;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

>>> rtl/core/text_console_writer_unit.sv
`timescale 1ns / 1ps
// Text console writer: ROWS x COLUMNS screen of 16-bit cells plus a cursor.
// req channel (req_valid/req_ready/req_data): one request per item, op selects
//   write character, clear screen, or read one cell. Each request gives one
//   rsp (rsp_valid/rsp_ready/rsp_data) with the cell read and the new cursor.
// cfg channel (cfg_valid/cfg_ready/cfg_data): text attribute byte, always
//   ready; write it only while no request is in flight.
// A read makes one registered read of the screen memory. A write that scrolls
//   copies rows 1..ROWS-1 up by one row and then blanks the bottom row; the
//   scroll is bound by the single write port of the screen memory.
// One request is worked on at a time; the next one is taken as soon as the
//   previous result sits in the output register.
// Reset: the screen is blanked by a sweep over all ROWS*COLUMNS cells (2000 at
//   the default size) with req_ready low; cfg writes are taken meanwhile.
// Receiver stall: one result waits in the output register; a further finished
//   request holds in the block and req_ready stays low until the slot frees.
`include "text_console_writer_unit_defines.svh"
module text_console_writer_unit
	import tcw_pkg::*;
#(
	parameter int COLUMNS = TCW_COLUMNS,
	parameter int ROWS    = TCW_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  tcw_req_t   req_data,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output tcw_rsp_t   rsp_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	tcw_cmd_t    cmd;
	tcw_status_t st;

	assign cfg_ready = 1'b1;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.st        (st),
		.cmd       (cmd)
	);

	tcw_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	`TCW_ASSERT_IMPLY(a_char_wr_no_clash, clk, arst_n, cmd.write_char, !st.wr_busy, "char write collides with sweep write")
	`TCW_ASSERT_IMPLY(a_scroll_last_row, clk, arst_n, cmd.start_copy, st.row_last, "scroll started off the last row")
	`TCW_ASSERT_IMPLY(a_scroll_col_home, clk, arst_n, rsp_valid && rsp_data.scrolled, rsp_data.cursor_col_now == 7'd0, "scroll left cursor off column zero")
	`TCW_ASSERT_NEXT(a_one_in_flight, clk, arst_n, cmd.load_item, !req_ready, "second request taken while busy")

endmodule
